// ----- src/dec_pkg.sv -----
`timescale 1ns / 1ps

package dec_pkg;

   // Class codes shared by the decision logic and the result payload.
   typedef logic [1:0] class_type;
   localparam class_type CLS_NOISE    = 2'd0;
   localparam class_type CLS_KNOCK    = 2'd1;
   localparam class_type CLS_DOORBELL = 2'd2;
   localparam class_type CLS_NONE     = 2'd3;

   // An event code carries the confirmed class; zero means no event.
   localparam class_type EVT_NONE = 2'd0;

   // Control register indexes and port widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 2'd2;

   typedef logic [7:0] run_type;
   localparam run_type RUN_MAX = 8'hFF;

   typedef struct packed {
      logic        is_silence;
      logic [15:0] prob_noise;
      logic [15:0] prob_knock;
      logic [15:0] prob_doorbell;
   } req_type;

   typedef struct packed {
      class_type   event_res;
      class_type   top_class;
      logic [15:0] confidence;
   } rsp_type;

   typedef struct packed {
      logic [15:0] detect_threshold;
      logic [7:0]  confirm_needed;
      logic [5:0]  noise_allowance;
   } cfg_type;

   localparam logic [15:0] THRESHOLD_RESET = 16'd32768;
   localparam logic [7:0]  CONFIRM_RESET   = 8'd2;
   localparam logic [5:0]  TOLERANCE_RESET = 6'd5;

   function automatic run_type sat_inc(run_type v);
      return (v == RUN_MAX) ? v : v + 8'd1;
   endfunction

endpackage

// ----- src/dec_stream_if.sv -----
`timescale 1ns / 1ps

interface dec_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/dec_tracker.sv -----
`timescale 1ns / 1ps

module dec_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  dec_pkg::req_type item,
   input  dec_pkg::cfg_type cfg,
   output dec_pkg::rsp_type result
);
   import dec_pkg::*;

   class_type   last_class_ff, last_class_in;
   run_type     confirm_run_ff, confirm_run_in;
   run_type     noise_run_ff, noise_run_in;
   run_type     uncertain_run_ff, uncertain_run_in;

   class_type   top;
   class_type   event_code;
   logic [15:0] best;
   logic [15:0] conf;
   run_type     noise_inc;
   run_type     uncertain_inc;
   logic [6:0]  uncertain_limit;

   always_comb begin
      last_class_in    = last_class_ff;
      confirm_run_in   = confirm_run_ff;
      noise_run_in     = noise_run_ff;
      uncertain_run_in = uncertain_run_ff;
      event_code       = EVT_NONE;

      // Ties go to the lower class index, so only a strictly larger value wins.
      top  = CLS_NOISE;
      best = item.prob_noise;
      if (item.prob_knock > item.prob_noise) begin
         top  = CLS_KNOCK;
         best = item.prob_knock;
      end
      if (item.prob_doorbell > best) begin
         top  = CLS_DOORBELL;
         best = item.prob_doorbell;
      end
      conf = best;

      noise_inc       = sat_inc(noise_run_ff);
      uncertain_inc   = sat_inc(uncertain_run_ff);
      uncertain_limit = {cfg.noise_allowance, 1'b0};

      if (item.is_silence) begin
         top              = CLS_NOISE;
         conf             = '0;
         noise_run_in     = noise_inc;
         uncertain_run_in = '0;
         if (noise_inc > {2'b00, cfg.noise_allowance}) begin
            last_class_in  = CLS_NOISE;
            confirm_run_in = '0;
         end
      end else if (top == CLS_NOISE) begin
         noise_run_in = noise_inc;
         if (noise_inc > {2'b00, cfg.noise_allowance}) begin
            last_class_in  = CLS_NOISE;
            confirm_run_in = '0;
         end
      end else if (conf < cfg.detect_threshold) begin
         uncertain_run_in = uncertain_inc;
         if (uncertain_inc > {1'b0, uncertain_limit}) begin
            last_class_in    = CLS_NONE;
            confirm_run_in   = '0;
            uncertain_run_in = '0;
         end
      end else begin
         noise_run_in     = '0;
         uncertain_run_in = '0;
         if (top == last_class_ff) begin
            confirm_run_in = sat_inc(confirm_run_ff);
         end else begin
            last_class_in  = top;
            confirm_run_in = 8'd1;
         end
         if (confirm_run_in >= cfg.confirm_needed) begin
            event_code = top;
         end
      end

      result.event_res  = event_code;
      result.top_class  = top;
      result.confidence = conf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_class_ff    <= CLS_NONE;
         confirm_run_ff   <= '0;
         noise_run_ff     <= '0;
         uncertain_run_ff <= '0;
      end else if (advance) begin
         last_class_ff    <= last_class_in;
         confirm_run_ff   <= confirm_run_in;
         noise_run_ff     <= noise_run_in;
         uncertain_run_ff <= uncertain_run_in;
      end
   end

endmodule

// ----- src/detection_event_confirmer.sv -----
`timescale 1ns / 1ps

// Confirms knock and doorbell detections from a stream of classifier verdicts.
// The block takes one verdict per clock cycle while req_if.ready is high and
// returns exactly one result beat for each, in order: a verdict is held in the
// input register, then the decision and run-counter update settle into a
// two-entry result buffer. req_if.ready depends only on registered state and
// drops only while both result buffer entries are held and a verdict waits.
// Control registers may be written only while no verdict is in flight.
module detection_event_confirmer (
   input  logic                              clock,
   input  logic                              reset,
   dec_stream_if.sink                        req_if,
   dec_stream_if.source                      rsp_if,
   input  logic                              csr_wr_en,
   input  logic [dec_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dec_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dec_pkg::*;

   cfg_type cfg_ff;

   logic    in_valid_ff;
   req_type in_item_ff;

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;

   rsp_type result;
   logic    advance;
   logic    pop;
   logic    req_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold <= THRESHOLD_RESET;
         cfg_ff.confirm_needed   <= CONFIRM_RESET;
         cfg_ff.noise_allowance  <= TOLERANCE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_ff.detect_threshold <= csr_wdata;
            CSR_CONFIRM:   cfg_ff.confirm_needed   <= csr_wdata[7:0];
            CSR_TOLERANCE: cfg_ff.noise_allowance  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // The verdict moves on whenever the result buffer has a free entry.
   assign advance      = in_valid_ff && !(head_valid_ff && skid_valid_ff);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_beat     = req_if.valid && req_if.ready;
   assign pop          = head_valid_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff <= req_if.payload;
      end
   end

   dec_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // A new result can only arrive while the skid entry is empty.
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = advance;
            head_in       = result;
         end
      end else if (advance) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid   = head_valid_ff;
   assign rsp_if.payload = head_ff;

endmodule

// ----- src/dec_checker.sv -----
`timescale 1ns / 1ps

module dec_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dec_pkg::rsp_type rsp_payload
);
   import dec_pkg::*;

   // An event always names the class that won the verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_res != EVT_NONE)
         |-> rsp_payload.top_class == rsp_payload.event_res)
      else $error("event code differs from the top class");

   // A noise or silence verdict never raises an event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.top_class == CLS_NOISE)
         |-> rsp_payload.event_res == EVT_NONE)
      else $error("event raised on a noise verdict");

   // Coming out of reset the block is empty and open for a beat.
   assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("block not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

endmodule

bind detection_event_confirmer dec_checker u_dec_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
